>>> rtl/kcg_pkg.sv
// Package for the k-combination generator: sizes, configuration register
// indexes, the controller state type and the command bundle sent to cells.
// No dependencies.
`default_nettype none

package kcg_pkg;

  localparam int MAX_EL   = 16;
  localparam int ELEM_W   = 4;
  localparam int SIZE_W   = 5;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd1;

  localparam logic [SIZE_W-1:0] SET_SIZE_RST    = 5'd4;
  localparam logic [SIZE_W-1:0] SUBSET_SIZE_RST = 5'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX        = 5'(MAX_EL);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic              init;   // load the first combination
    logic              adv;    // step to the next combination
    logic              load;   // copy the new member into the output chain
    logic              shift;  // move the output chain one cell left
    logic [SIZE_W-1:0] k;      // effective subset size
    logic [SIZE_W-1:0] lim;    // n - k, upper bound of cell 0
    logic [ELEM_W-1:0] piv;    // rightmost cell that can still advance
    logic [ELEM_W-1:0] base;   // combination[piv] + 1 - piv
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/kcg_cell.sv
// One cell of the combination row: holds one member and one stage of the
// output shift chain. Depends on kcg_pkg.
`default_nettype none

module kcg_cell (
  input  wire                  clk,
  input  kcg_pkg::cell_cmd_t   cmd,
  input  wire [3:0]            idx,
  input  wire [3:0]            right_in,
  output logic                 can_adv,
  output logic [3:0]           val,
  output logic [3:0]           head
);
  import kcg_pkg::*;

  logic [ELEM_W-1:0] c_r, c_nxt;
  logic [ELEM_W-1:0] sh_r, sh_nxt;

  // A member may advance while it stays below n - k + its own position.
  assign can_adv = ({1'b0, idx} < cmd.k) &&
                   ({2'b00, c_r} < ({1'b0, cmd.lim} + {2'b00, idx}));

  always_comb begin
    c_nxt = c_r;
    if (cmd.init) begin
      c_nxt = idx;
    end else if (cmd.adv && (idx >= cmd.piv)) begin
      // Pivot gets its old value plus one, later cells follow consecutively.
      c_nxt = cmd.base + idx;
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (cmd.load) begin
      sh_nxt = c_nxt;
    end else if (cmd.shift) begin
      sh_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    c_r  <= c_nxt;
    sh_r <= sh_nxt;
  end

  assign val  = c_r;
  assign head = sh_r;

endmodule

`default_nettype wire

>>> rtl/k_combination_generator.sv
// Top level of the lexicographic k-combination generator: controller,
// configuration registers and a row of kcg_cell instances.
// Depends on kcg_pkg and kcg_cell.
//
// Usage: each input item (in_tdata[0] = restart) requests one combination
// of k members out of {0..n-1}. The answer is k output items, member
// values ascending, the final one with out_tlast high; each carries the
// saturating count of combinations delivered so far. With k zero the one
// empty combination comes as a single item with out_tuser[0] set; once the
// enumeration is used up every request yields one item with out_tuser[1]
// set. n and k are written through the cfg port while idle; a write to n or
// k, a reset or a restart item begins the enumeration again.
// Timing: the next combination is formed in the cycle the request is
// accepted, by the row of cells in parallel; the first result item is
// valid in the cycle after, and the rest follow one per cycle through the
// cells' output shift chain while out_tready is high. A stall on out_tready
// simply holds the current item; no new request is taken until the last
// item of the current one is delivered.
// After reset n = 4, k = 2 and the enumeration starts from the beginning.
`default_nettype none

module k_combination_generator (
  input  wire         clk,
  input  wire         rst_n,
  // Input item: [0] restart, [7:1] zero
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,
  // Result item: [3:0] element, [7:4] position, [39:8] sequence_res
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  // Result flags: [0] empty_set, [1] exhausted
  output logic [1:0]  out_tuser,
  input  wire         cfg_wen,
  input  wire  [1:0]  cfg_index,
  input  wire  [4:0]  cfg_wdata
);
  import kcg_pkg::*;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  set_size_r, subset_size_r;
  logic               started_r, finished_r;
  logic [COUNT_W-1:0] delivered_r;
  logic [ELEM_W-1:0]  pos_r;
  logic               single_r, empty_r, exh_r;

  logic in_acc, out_acc;
  logic restart;
  logic st_eff, fin_eff;
  logic [COUNT_W-1:0] del_eff, del_new;
  logic [SIZE_W-1:0] n_eff, k_eff;
  logic k_zero, k_over;
  logic st_new, fin_new, do_init, do_adv, is_empty, bump;
  logic any_adv;
  logic [ELEM_W-1:0] piv;
  logic [ELEM_W-1:0] k_last;
  logic is_last;

  logic              can_adv [MAX_EL];
  logic [ELEM_W-1:0] val     [MAX_EL];
  logic [ELEM_W-1:0] head    [MAX_EL];
  cell_cmd_t cmd;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;
  assign restart = in_tdata[0];

  assign n_eff  = (set_size_r > SIZE_MAX) ? SIZE_MAX : set_size_r;
  assign k_eff  = (subset_size_r > SIZE_MAX) ? SIZE_MAX : subset_size_r;
  assign k_zero = (k_eff == '0);
  assign k_over = (k_eff > n_eff);

  assign st_eff  = started_r & ~restart;
  assign fin_eff = finished_r & ~restart;
  assign del_eff = restart ? '0 : delivered_r;

  // Rightmost cell that can still advance.
  always_comb begin
    any_adv = 1'b0;
    piv     = '0;
    for (int i = 0; i < MAX_EL; i++) begin
      if (can_adv[i]) begin
        any_adv = 1'b1;
        piv     = ELEM_W'(i);
      end
    end
  end

  always_comb begin
    st_new   = st_eff;
    fin_new  = fin_eff;
    do_init  = 1'b0;
    do_adv   = 1'b0;
    is_empty = 1'b0;
    if (!fin_eff) begin
      if (!st_eff) begin
        st_new = 1'b1;
        if (k_zero) begin
          fin_new  = 1'b1;
          is_empty = 1'b1;
        end else if (k_over) begin
          fin_new = 1'b1;
        end else begin
          do_init = 1'b1;
        end
      end else if (k_zero || k_over || !any_adv) begin
        fin_new = 1'b1;
      end else begin
        do_adv = 1'b1;
      end
    end
  end

  assign bump    = is_empty | ~fin_new;
  assign del_new = (bump && (del_eff != '1)) ? del_eff + 1'b1 : del_eff;

  assign cmd.init  = in_acc & do_init;
  assign cmd.adv   = in_acc & do_adv;
  assign cmd.load  = in_acc;
  assign cmd.shift = out_acc;
  assign cmd.k     = k_eff;
  assign cmd.lim   = n_eff - k_eff;
  assign cmd.piv   = piv;
  assign cmd.base  = val[piv] + 1'b1 - piv;

  for (genvar g = 0; g < MAX_EL; g++) begin : g_cell
    logic [ELEM_W-1:0] right;
    if (g == MAX_EL - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = head[g+1];
    end
    kcg_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (ELEM_W'(g)),
      .right_in (right),
      .can_adv  (can_adv[g]),
      .val      (val[g]),
      .head     (head[g])
    );
  end

  assign k_last  = ELEM_W'(k_eff - 1'b1);
  assign is_last = single_r | (pos_r == k_last);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && is_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs; no request is taken while reset is held.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready  = rst_n;
      ST_EMIT: out_tvalid = 1'b1;
      default: in_tready  = 1'b0;
    endcase
  end

  assign out_tdata = {delivered_r, pos_r, (single_r ? {ELEM_W{1'b0}} : head[0])};
  assign out_tlast = is_last;
  assign out_tuser = {exh_r, empty_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= SUBSET_SIZE_RST;
      started_r     <= 1'b0;
      finished_r    <= 1'b0;
      delivered_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen && ((cfg_index == CFG_SET_SIZE) || (cfg_index == CFG_SUBSET_SIZE))) begin
        if (cfg_index == CFG_SET_SIZE) begin
          set_size_r <= cfg_wdata;
        end else begin
          subset_size_r <= cfg_wdata;
        end
        started_r   <= 1'b0;
        finished_r  <= 1'b0;
        delivered_r <= '0;
      end else if (in_acc) begin
        started_r   <= st_new;
        finished_r  <= fin_new;
        delivered_r <= del_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r    <= '0;
      single_r <= fin_new;
      empty_r  <= is_empty;
      exh_r    <= fin_new & ~is_empty;
    end else if (out_acc) begin
      pos_r <= pos_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for k_combination_generator: a scoreboard class
// predicts every combination item and checks the stream on the result side.
// Depends on kcg_pkg and the k_combination_generator RTL.
`timescale 1ns / 100ps

module tb_top;
  import kcg_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 350;
  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [ELEM_W-1:0]  position;
    logic               last;
    logic               empty_set;
    logic               exhausted;
    logic [COUNT_W-1:0] seq;
  } comb_item_t;

  class comb_scoreboard;
    bit [SIZE_W-1:0]  set_size_q;
    bit [SIZE_W-1:0]  subset_size_q;
    int               members[MAX_EL];
    bit               started;
    bit               finished;
    bit [COUNT_W-1:0] delivered;
    comb_item_t       pending_items[$];
    int               mismatches;
    int               results_seen;
    int               requests_seen;

    function new();
      set_size_q = SET_SIZE_RST;
      subset_size_q = SUBSET_SIZE_RST;
      foreach (members[i]) members[i] = 0;
      mismatches = 0;
      results_seen = 0;
      requests_seen = 0;
      clear_enum();
    endfunction

    function void clear_enum();
      started = 1'b0;
      finished = 1'b0;
      delivered = '0;
    endfunction

    function int pending();
      return pending_items.size();
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [SIZE_W-1:0] val);
      if (idx == CFG_SET_SIZE) begin
        set_size_q = val;
      end else if (idx == CFG_SUBSET_SIZE) begin
        subset_size_q = val;
      end else begin
        return;
      end
      clear_enum();
    endfunction

    function void push_item(int elem, int pos, bit last, bit empty, bit exh);
      comb_item_t it;
      it.element = elem[ELEM_W-1:0];
      it.position = pos[ELEM_W-1:0];
      it.last = last;
      it.empty_set = empty;
      it.exhausted = exh;
      it.seq = delivered;
      pending_items.push_back(it);
    endfunction

    function void bump_count();
      if (delivered != '1) delivered++;
    endfunction

    function void note_request(bit restart);
      int n;
      int k;
      int i;
      int j;
      n = (set_size_q > SIZE_MAX) ? MAX_EL : int'(set_size_q);
      k = (subset_size_q > SIZE_MAX) ? MAX_EL : int'(subset_size_q);
      requests_seen++;
      if (restart) clear_enum();
      if (!finished) begin
        if (!started) begin
          started = 1'b1;
          if (k == 0) begin
            // The single empty combination, then nothing more.
            finished = 1'b1;
            bump_count();
            push_item(0, 0, 1'b1, 1'b1, 1'b0);
            return;
          end
          if (k > n) begin
            finished = 1'b1;
          end else begin
            for (i = 0; i < k; i++) members[i] = i;
          end
        end else if (k == 0 || k > n) begin
          finished = 1'b1;
        end else begin
          // Advance the rightmost member that still has room, then pack the rest.
          i = k - 1;
          while (i >= 0 && members[i] >= n - k + i) i--;
          if (i < 0) begin
            finished = 1'b1;
          end else begin
            members[i] = members[i] + 1;
            for (j = i + 1; j < k; j++) members[j] = members[j-1] + 1;
          end
        end
      end
      if (finished) begin
        push_item(0, 0, 1'b1, 1'b0, 1'b1);
        return;
      end
      bump_count();
      for (i = 0; i < k; i++) push_item(members[i], i, i == k - 1, 1'b0, 1'b0);
    endfunction

    function void check_result(logic [39:0] data, logic last, logic [1:0] flags);
      comb_item_t got;
      comb_item_t want;
      got.element = data[3:0];
      got.position = data[7:4];
      got.seq = data[39:8];
      got.last = last;
      got.empty_set = flags[0];
      got.exhausted = flags[1];
      results_seen++;
      if (pending_items.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item: expected none, actual elem=%0d pos=%0d",
                 $time, got.element, got.position);
        $display("  last=%b empty=%b exh=%b seq=%0d",
                 got.last, got.empty_set, got.exhausted, got.seq);
        return;
      end
      want = pending_items.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: result mismatch", $time);
        $display("  expected elem=%0d pos=%0d last=%b empty=%b exh=%b seq=%0d",
                 want.element, want.position, want.last, want.empty_set,
                 want.exhausted, want.seq);
        $display("  actual   elem=%0d pos=%0d last=%b empty=%b exh=%b seq=%0d",
                 got.element, got.position, got.last, got.empty_set,
                 got.exhausted, got.seq);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // Fields: [0] restart
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // Fields: [3:0] element, [7:4] position, [39:8] sequence_res
  logic [39:0] out_tdata;
  logic        out_tlast;
  // Fields: [0] empty_set, [1] exhausted
  logic [1:0]  out_tuser;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [4:0]  cfg_wdata = 5'd0;

  comb_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int idle_cycles = 0;
  int cfg_writes = 0;
  int phases = 0;

  k_combination_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random back-pressure, checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  task automatic set_idle(input int in_pct, input int out_pct);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
  endtask

  // A request may stay valid back to back; it is lowered ahead of a gap or a drain.
  task automatic send_request(input bit restart);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(restart);
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val);
    cfg_writes++;
    @(posedge clk);
  endtask

  initial begin
    int random_sent;
    int count;
    int n;
    int k;
    random_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: all six pairs of four, then the exhausted answer twice.
    set_idle(0, 0);
    repeat (8) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    // Writes to undecoded indexes must leave the enumeration running.
    drain(3);
    write_cfg(CFG_UNUSED_A, 5'd31);
    write_cfg(CFG_UNUSED_B, 5'd0);
    send_request(1'b0);
    drain(3);
    write_cfg(CFG_SET_SIZE, 5'd16);
    write_cfg(CFG_SUBSET_SIZE, 5'd16);
    repeat (2) send_request(1'b0);
    drain(3);
    write_cfg(CFG_SUBSET_SIZE, 5'd0);
    repeat (2) send_request(1'b0);
    drain(3);
    write_cfg(CFG_SET_SIZE, 5'd3);
    write_cfg(CFG_SUBSET_SIZE, 5'd5);
    send_request(1'b0);
    // Oversized registers behave as the maximum.
    drain(3);
    write_cfg(CFG_SET_SIZE, 5'd31);
    write_cfg(CFG_SUBSET_SIZE, 5'd31);
    send_request(1'b0);
    drain(3);
    write_cfg(CFG_SET_SIZE, 5'd0);
    write_cfg(CFG_SUBSET_SIZE, 5'd0);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    drain(3);
    write_cfg(CFG_SET_SIZE, 5'd16);
    write_cfg(CFG_SUBSET_SIZE, 5'd1);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    drain(3);

    while (random_sent < RANDOM_ITEMS) begin
      case (phases % 4)
        0: set_idle(0, 0);
        1: set_idle(56, 0);
        2: set_idle(0, 56);
        default: set_idle(26, 26);
      endcase
      drain(3);
      // Mostly small sets so that enumerations run out within a phase.
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(0, 7);
        k = $urandom_range(0, n + 1);
      end else begin
        n = $urandom_range(0, 31);
        k = $urandom_range(0, 31);
      end
      if ($urandom_range(0, 3) == 0)
        write_cfg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                  5'($urandom_range(0, 31)));
      if ($urandom_range(0, 4) != 0) write_cfg(CFG_SET_SIZE, 5'(n));
      if ($urandom_range(0, 4) != 0) write_cfg(CFG_SUBSET_SIZE, 5'(k));
      count = $urandom_range(10, 40);
      repeat (count) begin
        send_request($urandom_range(0, 99) < 8);
        random_sent++;
      end
      phases++;
    end

    drain(20);
    $display("Covered %0d requests and %0d result items, %0d register writes, %0d random phases.",
             sb.requests_seen, sb.results_seen, cfg_writes, phases);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d items still expected", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
